@@ rtl/core/ttsc_pkg.sv @@
// shared types and constants for the team/type sorted census
`timescale 1ns / 1ps
package ttsc_pkg;
   localparam int MaxUnits  = 256;
   localparam int AddrBits  = 8;
   localparam int CountBits = 9;
   localparam int TeamBits  = 7;
   localparam int TypeBits  = 16;
   localparam int KeyBits   = 23;
   localparam int IdBits    = 24;
   localparam int EntryBits = KeyBits + IdBits;

   typedef enum logic [2:0] {
      MODE_CLEAR = 3'd0,
      MODE_LOAD  = 3'd1,
      MODE_SORT  = 3'd2,
      MODE_QTYPE = 3'd3,
      MODE_QTEAM = 3'd4,
      MODE_READ  = 3'd5
   } mode_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SORT_OUTER,
      ST_SORT_RD_I,
      ST_SORT_WAIT_I,
      ST_SORT_RD_J,
      ST_SORT_CMP,
      ST_SORT_PLACE,
      ST_SRCH_RD,
      ST_SRCH_CMP,
      ST_READ_WAIT,
      ST_DONE
   } state_type;
endpackage

@@ rtl/core/ttsc_ram.sv @@
// generic single-port ram with registered read
`timescale 1ns / 1ps
module ttsc_ram #(
   parameter int Width = 8,
   parameter int Depth = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] addr,
   input  logic [Width-1:0]         wr_data,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data_ff <= mem[addr];
   end

   assign rd_data = rd_data_ff;
endmodule

@@ rtl/core/team_type_sorted_census.sv @@
// top level of the team/type sorted census
`timescale 1ns / 1ps
// sorted table of units keyed by team (high bits) and unit type (low 16 bits)
// req channel: one command per transfer (clear, load, sort, query, read)
// rsp channel: exactly one result transfer per command, in order
// table entries live in one ram of 256 words (key and slot/generation)
// work per command:
//   clear, load, unused modes: acted on when taken, then the result
//   read entry: one ram read, then the result
//   queries: 2 binary searches, one ram read per probe, at most 9 probes each
//   sort: insertion sort, shifting each larger neighbor up one place,
//     longest for a full reversed table
// one command is handled at a time; every step shares the single ram port
// a new command is taken at the earliest in the cycle the held result transfers
// when the receiver stalls, the result holds and further commands wait
// reset empties the table and clears the overflow flag; no clearing pass
module team_type_sorted_census
   import ttsc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // mode[2:0], slot[10:3], slot_alive[11], army_index[19:12],
   // unit_type[35:20], unit_generation[51:36], query_team[58:52],
   // query_type[74:59], read_position[82:75], zero fill [87:83]
   input  logic [87:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // range_begin[8:0], range_end[17:9], entry_slot[25:18],
   // entry_generation[41:26], entry_total[50:42], overflow[51], zero fill
   output logic [55:0] rsp_tdata
);
   // request fields
   logic [2:0]          f_mode;
   logic [7:0]          f_slot;
   logic                f_alive;
   logic [7:0]          f_army;
   logic [15:0]         f_utype;
   logic [15:0]         f_ugen;
   logic [TeamBits-1:0] f_qteam;
   logic [15:0]         f_qtype;
   logic [7:0]          f_rpos;

   assign f_mode  = req_tdata[2:0];
   assign f_slot  = req_tdata[10:3];
   assign f_alive = req_tdata[11];
   assign f_army  = req_tdata[19:12];
   assign f_utype = req_tdata[35:20];
   assign f_ugen  = req_tdata[51:36];
   assign f_qteam = req_tdata[58:52];
   assign f_qtype = req_tdata[74:59];
   assign f_rpos  = req_tdata[82:75];

   state_type state_ff, state_in;

   logic [CountBits-1:0] count_ff, count_in;
   logic                 ovf_ff, ovf_in;

   // sort / search working registers
   logic [CountBits-1:0] i_ff, i_in;     // outer index
   logic [CountBits-1:0] j_ff, j_in;     // insertion position
   logic [EntryBits-1:0] hold_ff, hold_in; // entry being inserted
   logic [CountBits-1:0] lo_ff, lo_in;
   logic [CountBits-1:0] hi_ff, hi_in;
   logic                 pass_ff, pass_in;  // 0 lower bound, 1 upper bound
   logic [KeyBits-1:0]   klow_ff, klow_in;
   logic [KeyBits-1:0]   khigh_ff, khigh_in;
   logic [CountBits-1:0] rb_ff, rb_in;
   logic                 is_read_ff, is_read_in;
   logic                 rd_ok_ff, rd_ok_in;

   // result register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [55:0]          rsp_data_ff, rsp_data_in;

   // ram port
   logic                 ram_we;
   logic [AddrBits-1:0]  ram_addr;
   logic [EntryBits-1:0] ram_wdata, ram_rdata;

   ttsc_ram #(.Width(EntryBits), .Depth(MaxUnits)) u_table (
      .clock  (clock),
      .wr_en  (ram_we),
      .addr   (ram_addr),
      .wr_data(ram_wdata),
      .rd_data(ram_rdata)
   );

   // entry layout: key in high bits, slot then generation below
   logic [KeyBits-1:0] rd_key, hold_key;
   logic [7:0]         rd_slot, hold_slot;
   assign rd_key    = ram_rdata[EntryBits-1:IdBits];
   assign rd_slot   = ram_rdata[IdBits-1:16];
   assign hold_key  = hold_ff[EntryBits-1:IdBits];
   assign hold_slot = hold_ff[IdBits-1:16];

   logic                 sorts_after;
   logic [CountBits-1:0] mid;
   logic                 probe_lt;
   logic                 accept;
   logic                 out_free;

   assign sorts_after = (rd_key != hold_key) ? (rd_key > hold_key) : (rd_slot > hold_slot);
   assign mid         = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign probe_lt    = pass_ff ? (rd_key <= khigh_ff) : (rd_key < klow_ff);
   assign out_free    = !rsp_valid_ff || rsp_tready;
   assign req_tready  = (state_ff == ST_IDLE) && out_free;
   assign accept      = req_tvalid && req_tready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (f_mode)
                  MODE_SORT:  state_in = ST_SORT_OUTER;
                  MODE_QTYPE: state_in = ST_SRCH_RD;
                  MODE_QTEAM: state_in = ST_SRCH_RD;
                  MODE_READ:  state_in = ST_READ_WAIT;
                  default:    state_in = ST_DONE;
               endcase
            end
         end
         ST_SORT_OUTER:  state_in = (i_ff < count_ff) ? ST_SORT_RD_I : ST_DONE;
         ST_SORT_RD_I:   state_in = ST_SORT_WAIT_I;
         ST_SORT_WAIT_I: state_in = ST_SORT_RD_J;
         ST_SORT_RD_J:   state_in = (j_ff == '0) ? ST_SORT_PLACE : ST_SORT_CMP;
         ST_SORT_CMP:    state_in = sorts_after ? ST_SORT_RD_J : ST_SORT_PLACE;
         ST_SORT_PLACE:  state_in = ST_SORT_OUTER;
         ST_SRCH_RD:     state_in = (lo_ff < hi_ff) ? ST_SRCH_CMP
                                    : (pass_ff ? ST_DONE : ST_SRCH_RD);
         ST_SRCH_CMP:    state_in = ST_SRCH_RD;
         ST_READ_WAIT:   state_in = ST_DONE;
         ST_DONE:        state_in = out_free ? ST_IDLE : ST_DONE;
         default:        state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      hold_in      = hold_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      pass_in      = pass_ff;
      klow_in      = klow_ff;
      khigh_in     = khigh_ff;
      rb_in        = rb_ff;
      is_read_in   = is_read_ff;
      rd_ok_in     = rd_ok_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      ram_we       = 1'b0;
      ram_addr     = '0;
      ram_wdata    = hold_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rb_in      = '0;
               lo_in      = '0;
               hi_in      = '0;
               is_read_in = 1'b0;
               pass_in    = 1'b0;
               i_in       = 9'd1;
               hi_in      = count_ff;
               klow_in    = {f_qteam, (f_mode == MODE_QTYPE) ? f_qtype : 16'h0000};
               khigh_in   = {f_qteam, (f_mode == MODE_QTYPE) ? f_qtype : 16'hFFFF};
               case (f_mode)
                  MODE_CLEAR: begin
                     count_in = '0;
                     ovf_in   = 1'b0;
                  end
                  MODE_LOAD: begin
                     if (f_alive && !f_army[7]) begin
                        if (count_ff < CountBits'(MaxUnits)) begin
                           ram_we    = 1'b1;
                           ram_addr  = count_ff[AddrBits-1:0];
                           ram_wdata = {f_army[TeamBits-1:0], f_utype, f_slot, f_ugen};
                           count_in  = count_ff + 1'b1;
                        end else begin
                           ovf_in = 1'b1;
                        end
                     end
                  end
                  MODE_READ: begin
                     ram_addr   = f_rpos;
                     is_read_in = 1'b1;
                     rd_ok_in   = {1'b0, f_rpos} < count_ff;
                  end
                  default: ;
               endcase
            end
         end
         ST_SORT_RD_I: begin
            ram_addr = i_ff[AddrBits-1:0];
            j_in     = i_ff;
         end
         ST_SORT_WAIT_I: begin
            hold_in = ram_rdata;
         end
         ST_SORT_RD_J: begin
            ram_addr = AddrBits'(j_ff - 1'b1);
         end
         ST_SORT_CMP: begin
            // shift the larger neighbor up one place
            if (sorts_after) begin
               ram_we    = 1'b1;
               ram_addr  = j_ff[AddrBits-1:0];
               ram_wdata = ram_rdata;
               j_in      = j_ff - 1'b1;
            end
         end
         ST_SORT_PLACE: begin
            ram_we    = 1'b1;
            ram_addr  = j_ff[AddrBits-1:0];
            ram_wdata = hold_ff;
            i_in      = i_ff + 1'b1;
         end
         ST_SRCH_RD: begin
            ram_addr = mid[AddrBits-1:0];
            if (!(lo_ff < hi_ff) && !pass_ff) begin
               // lower bound done, upper bound starts there
               rb_in   = lo_ff;
               pass_in = 1'b1;
               hi_in   = count_ff;
            end
         end
         ST_SRCH_CMP: begin
            if (probe_lt) begin
               lo_in = mid + 1'b1;
            end else begin
               hi_in = mid;
            end
         end
         ST_READ_WAIT: begin
            hold_in = rd_ok_ff ? ram_rdata : '0;
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {4'b0000, ovf_ff, count_ff,
                               is_read_ff ? hold_ff[15:0] : 16'h0000,
                               is_read_ff ? hold_ff[IdBits-1:16] : 8'h00,
                               pass_ff ? lo_ff : 9'd0,
                               pass_ff ? rb_ff : 9'd0};
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pass_ff      <= 1'b0;
         is_read_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
         pass_ff      <= pass_in;
         is_read_ff   <= is_read_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff        <= i_in;
      j_ff        <= j_in;
      hold_ff     <= hold_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      klow_ff     <= klow_in;
      khigh_ff    <= khigh_in;
      rb_ff       <= rb_in;
      rd_ok_ff    <= rd_ok_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // table never holds more than its capacity
   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CountBits'(MaxUnits))
      else $error("entry count beyond capacity");

   // search window stays inside the table
   a_search_window: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SRCH_CMP) |-> (lo_ff < hi_ff && hi_ff <= count_ff))
      else $error("search window out of range");

   // sort never writes past the filled part
   a_sort_write: assert property (@(posedge clock) disable iff (reset)
      (ram_we && state_ff != ST_IDLE) |-> ({1'b0, ram_addr} < count_ff))
      else $error("sort write past end of table");

   // a command is never taken while a sort or search runs
   a_busy_block: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req_tready)
      else $error("ready while busy");
endmodule

@@ verif/team_type_sorted_census_checker.sv @@
// census result checker: watches both channels, predicts each result and compares it
`timescale 1ns / 1ps
module team_type_sorted_census_checker
   import ttsc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [87:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [55:0] rsp_tdata,
   output int          fail_count,
   output int          pending
);
   // listed from the highest bit down, so range_begin lands in the lowest bits
   typedef struct packed {
      logic        overflow;
      logic [8:0]  entry_total;
      logic [15:0] entry_generation;
      logic [7:0]  entry_slot;
      logic [8:0]  range_end;
      logic [8:0]  range_begin;
   } census_result_type;

   logic [KeyBits-1:0] key_tab [MaxUnits];
   logic [IdBits-1:0]  id_tab  [MaxUnits];
   int                 unit_count;
   logic               full_flag;
   census_result_type  awaited_q [$];

   function automatic logic [KeyBits-1:0] census_key(input logic [15:0] team,
                                                     input logic [15:0] utype);
      return {team[TeamBits-1:0], utype[TypeBits-1:0]};
   endfunction

   // stable insertion sort by key, then by slot
   function automatic void sort_units();
      logic [KeyBits-1:0] k;
      logic [IdBits-1:0]  d;
      int                 j;
      for (int i = 1; i < unit_count; i++) begin
         k = key_tab[i];
         d = id_tab[i];
         j = i;
         while (j > 0 && (key_tab[j-1] > k ||
                (key_tab[j-1] == k && id_tab[j-1][23:16] > d[23:16]))) begin
            key_tab[j] = key_tab[j-1];
            id_tab[j]  = id_tab[j-1];
            j--;
         end
         key_tab[j] = k;
         id_tab[j]  = d;
      end
   endfunction

   // lower bound of low, then upper bound of high from there
   function automatic void search_run(input logic [KeyBits-1:0] low,
                                      input logic [KeyBits-1:0] high,
                                      output int first, output int last);
      int lo, hi, mid;
      lo = 0;
      hi = unit_count;
      while (lo < hi) begin
         mid = lo + ((hi - lo) >> 1);
         if (key_tab[mid] < low) lo = mid + 1;
         else hi = mid;
      end
      first = lo;
      hi = unit_count;
      while (lo < hi) begin
         mid = lo + ((hi - lo) >> 1);
         if (key_tab[mid] <= high) lo = mid + 1;
         else hi = mid;
      end
      last = lo;
   endfunction

   function automatic census_result_type apply_command(input logic [87:0] d);
      census_result_type r;
      int                first, last;
      logic [7:0]        army;
      logic [7:0]        rpos;
      r    = '0;
      army = d[19:12];
      rpos = d[82:75];
      case (d[2:0])
         MODE_CLEAR: begin
            unit_count = 0;
            full_flag  = 1'b0;
         end
         MODE_LOAD: begin
            if (d[11] && !army[7]) begin
               if (unit_count < MaxUnits) begin
                  key_tab[unit_count] = census_key({8'd0, army}, d[35:20]);
                  id_tab[unit_count]  = {d[10:3], d[51:36]};
                  unit_count++;
               end else begin
                  full_flag = 1'b1;
               end
            end
         end
         MODE_SORT: sort_units();
         MODE_QTYPE: begin
            search_run(census_key({9'd0, d[58:52]}, d[74:59]),
                       census_key({9'd0, d[58:52]}, d[74:59]), first, last);
            r.range_begin = first[8:0];
            r.range_end   = last[8:0];
         end
         MODE_QTEAM: begin
            search_run(census_key({9'd0, d[58:52]}, 16'h0000),
                       census_key({9'd0, d[58:52]}, 16'hFFFF), first, last);
            r.range_begin = first[8:0];
            r.range_end   = last[8:0];
         end
         MODE_READ: begin
            if (rpos < unit_count) begin
               r.entry_slot       = id_tab[rpos][23:16];
               r.entry_generation = id_tab[rpos][15:0];
            end
         end
         default: ;
      endcase
      r.entry_total = unit_count[8:0];
      r.overflow    = full_flag;
      return r;
   endfunction

   task automatic compare_field(input string name, input int exp_v, input int act_v);
      if (exp_v != act_v) begin
         $error("%s expected %0d actual %0d", name, exp_v, act_v);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      census_result_type want, got;
      if (reset) begin
         unit_count = 0;
         full_flag  = 1'b0;
         fail_count = 0;
         awaited_q.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[51:0];
            if (awaited_q.size() == 0) begin
               $error("result transfer with no command outstanding");
               fail_count++;
            end else begin
               want = awaited_q.pop_front();
               compare_field("range_begin", want.range_begin, got.range_begin);
               compare_field("range_end", want.range_end, got.range_end);
               compare_field("entry_slot", want.entry_slot, got.entry_slot);
               compare_field("entry_generation", want.entry_generation,
                             got.entry_generation);
               compare_field("entry_total", want.entry_total, got.entry_total);
               compare_field("overflow", want.overflow, got.overflow);
            end
         end
         if (req_tvalid && req_tready)
            awaited_q = {awaited_q, apply_command(req_tdata)};
      end
      pending = awaited_q.size();
   end
endmodule

@@ verif/team_type_sorted_census_tb.sv @@
// testbench top for the team/type sorted census: stimulus, stalls and verdict
`timescale 1ns / 1ps
module team_type_sorted_census_tb;
   import ttsc_pkg::*;

   // spare mode codes the block must treat as no-ops
   localparam logic [2:0] MODE_SPARE_A = 3'd6;
   localparam logic [2:0] MODE_SPARE_B = 3'd7;
   localparam int CMD_TARGET  = 1050;
   localparam int CYCLE_LIMIT = 3000000;
   localparam int HOLD_CYCLES = 600;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   // mode, slot, slot_alive, army_index, unit_type, unit_generation,
   // query_team, query_type, read_position, zero fill (lowest bit up)
   logic [87:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // range_begin, range_end, entry_slot, entry_generation, entry_total,
   // overflow, zero fill (lowest bit up)
   logic [55:0] rsp_tdata;

   int   fail_count;
   int   pending;
   int   cmds_sent = 0;
   int   table_fill = 0;          // rough fill, only steers read positions
   int   cycle_count = 0;
   bit   quiet = 1'b0;            // no new random gaps or stalls on either side while set
   bit   hold_request = 1'b0;     // asks the receiver for one long hold-off
   logic [6:0]  seen_team [$];
   logic [15:0] seen_type [$];

   team_type_sorted_census dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   team_type_sorted_census_checker census_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // watchdog: the slowest legal run is far below this
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // receiver: short random stalls, rare long ones, one long hold-off on request
   initial begin
      int stall_left;
      bit held;
      stall_left = 0;
      held       = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request && !held) begin
            rsp_tready <= 1'b0;
            held = 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
            if (!quiet && $urandom_range(0, 99) < 25)
               stall_left = ($urandom_range(0, 99) < 5) ? $urandom_range(15, 60)
                                                        : $urandom_range(1, 3);
         end
      end
   end

   // one transfer on the req channel, with a random gap before it
   task automatic send_cmd(input logic [87:0] d);
      int gap;
      gap = 0;
      if (!quiet && $urandom_range(0, 99) < 40)
         gap = ($urandom_range(0, 99) < 6) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= d;
      forever begin
         @(negedge clock);
         if (req_tready) break;
      end
      @(posedge clock);
      cmds_sent++;
   endtask

   // random bits in every field the mode does not use
   function automatic logic [87:0] noisy_cmd(input logic [2:0] mode);
      logic [87:0] d;
      d = {$urandom, $urandom, $urandom};
      d[2:0]   = mode;
      d[87:83] = '0;
      return d;
   endfunction

   task automatic do_plain(input logic [2:0] mode);
      if (mode == MODE_CLEAR) begin
         table_fill = 0;
         seen_team.delete();
         seen_type.delete();
      end
      send_cmd(noisy_cmd(mode));
   endtask

   task automatic do_load(input logic [7:0] slot, input logic alive, input logic [7:0] army,
                          input logic [15:0] utype, input logic [15:0] ugen);
      logic [87:0] d;
      d = noisy_cmd(MODE_LOAD);
      d[10:3]  = slot;
      d[11]    = alive;
      d[19:12] = army;
      d[35:20] = utype;
      d[51:36] = ugen;
      if (alive && !army[7]) begin
         table_fill++;
         seen_team = {seen_team, army[6:0]};
         seen_type = {seen_type, utype};
      end
      send_cmd(d);
   endtask

   task automatic do_query(input logic [2:0] mode, input logic [6:0] team,
                           input logic [15:0] qtype);
      logic [87:0] d;
      d = noisy_cmd(mode);
      d[58:52] = team;
      d[74:59] = qtype;
      send_cmd(d);
   endtask

   task automatic do_read(input logic [7:0] pos);
      logic [87:0] d;
      d = noisy_cmd(MODE_READ);
      d[82:75] = pos;
      send_cmd(d);
   endtask

   // clear, a batch of loads, usually a sort, then mixed queries, reads and spare modes
   task automatic run_batch(input int n_loads);
      int          n_ops, pick, k;
      logic [7:0]  slot, army;
      logic [15:0] utype;
      logic [6:0]  team;
      do_plain(MODE_CLEAR);
      slot = $urandom_range(0, 20);
      for (int i = 0; i < n_loads; i++) begin
         army  = ($urandom_range(0, 99) < 8) ? 8'($urandom_range(128, 255))
               : ($urandom_range(0, 1) ? 8'($urandom_range(0, 3)) : 8'($urandom_range(0, 127)));
         utype = $urandom_range(0, 1) ? 16'($urandom_range(0, 4)) : 16'($urandom);
         do_load(slot, $urandom_range(0, 99) < 90, army, utype, 16'($urandom));
         if (slot < 8'd254) slot += 8'($urandom_range(0, 2));
      end
      if ($urandom_range(0, 7) != 0) do_plain(MODE_SORT);
      n_ops = $urandom_range(5, 20);
      for (int i = 0; i < n_ops; i++) begin
         pick = $urandom_range(0, 99);
         k    = (seen_team.size() > 0) ? $urandom_range(0, seen_team.size() - 1) : 0;
         team  = (seen_team.size() > 0 && $urandom_range(0, 99) < 70) ? seen_team[k]
                                                                      : 7'($urandom);
         utype = (seen_type.size() > 0 && $urandom_range(0, 99) < 70) ? seen_type[k]
                                                                      : 16'($urandom);
         if (pick < 35) do_query(MODE_QTYPE, team, utype);
         else if (pick < 60) do_query(MODE_QTEAM, team, utype);
         else if (pick < 90)
            do_read($urandom_range(0, 9) == 0 ? 8'($urandom)
                    : 8'($urandom_range(0, (table_fill > 252) ? 255 : table_fill + 3)));
         else do_plain($urandom_range(0, 1) ? MODE_SPARE_A : MODE_SPARE_B);
      end
   endtask

   initial begin
      int full_batches;
      full_batches = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: empty table, skipped loads, extremes, equal key and slot
      do_read(8'd0);
      do_query(MODE_QTEAM, 7'd0, 16'd0);
      do_load(8'd3, 1'b0, 8'd5, 16'd1, 16'd1);
      do_load(8'd4, 1'b1, 8'hFF, 16'd1, 16'd1);
      do_load(8'd5, 1'b1, 8'h80, 16'd2, 16'd2);
      do_load(8'd255, 1'b1, 8'd127, 16'hFFFF, 16'hFFFF);
      do_load(8'd10, 1'b1, 8'd0, 16'd0, 16'd0);
      do_load(8'd10, 1'b1, 8'd0, 16'd0, 16'hAAAA);
      do_load(8'd7, 1'b1, 8'd0, 16'd0, 16'h5555);
      do_load(8'd8, 1'b1, 8'd64, 16'h8000, 16'h1234);
      do_query(MODE_QTYPE, 7'd0, 16'd0);          // query before sort
      do_plain(MODE_SORT);
      do_query(MODE_QTYPE, 7'd0, 16'd0);
      do_query(MODE_QTYPE, 7'd127, 16'hFFFF);
      do_query(MODE_QTEAM, 7'd64, 16'd0);
      do_query(MODE_QTEAM, 7'd1, 16'd0);          // absent team
      for (int i = 0; i < 5; i++) do_read(8'(i));
      do_read(8'd255);                             // read past end
      do_plain(MODE_SPARE_A);
      do_plain(MODE_SPARE_B);

      // random batches; two of them fill the table and run into overflow
      while (cmds_sent < CMD_TARGET) begin
         quiet = ($urandom_range(0, 5) == 0);
         if (cmds_sent > 400) hold_request = 1'b1;
         if (full_batches < 2 && cmds_sent > 200 * (full_batches + 1)) begin
            full_batches++;
            // enough loads that the kept ones pass capacity despite skips
            run_batch(330 + $urandom_range(1, 20));
         end else begin
            run_batch($urandom_range(0, 40));
         end
      end
      quiet = 1'b0;
      req_tvalid <= 1'b0;

      @(posedge clock);
      wait (pending == 0);
      repeat (200) @(posedge clock);
      if (fail_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end
endmodule
